[rtl/core/ega_logo_pixel_expander_unit_macros.svh]
// ---------------------------------------------------------------------------
// EGA logo pixel expander assertion macros
// Concurrent check helpers, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef EGA_LOGO_PIXEL_EXPANDER_UNIT_MACROS_SVH
`define EGA_LOGO_PIXEL_EXPANDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define ELPE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("elpe assertion failed");

`define ELPE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("elpe assertion failed");

`else

`define ELPE_ASSERT_NOW(label, ante, cons)
`define ELPE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/elpe_pkg.sv]
// ---------------------------------------------------------------------------
// EGA logo pixel expander package
// Shared widths, codes and the fixed 16-colour EGA palette.
// ---------------------------------------------------------------------------
`default_nettype none

package elpe_pkg;

	localparam int PALETTE_ENTRIES = 16;
	localparam int PIXELS_PER_BYTE = 8;
	localparam int PAL_IDX_W       = $clog2(PALETTE_ENTRIES);
	localparam int PIX_CNT_W       = $clog2(PIXELS_PER_BYTE);
	localparam int RGB_W           = 24;
	localparam int COMP_W          = 6;
	localparam int PLANE_W         = 8;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 8;

	typedef logic [PAL_IDX_W-1:0]  pal_idx_t;
	typedef logic [PIX_CNT_W-1:0]  pix_cnt_t;
	typedef logic [RGB_W-1:0]      rgb_t;
	typedef logic [PLANE_W-1:0]    plane_t;
	typedef logic [COMP_W-1:0]     comp_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam pix_cnt_t LAST_PIX = pix_cnt_t'(PIXELS_PER_BYTE - 1);

	localparam logic KIND_PIXELS    = 1'b0;
	localparam logic KIND_PAL_WRITE = 1'b1;

	localparam logic MODE_ATTR   = 1'b0;
	localparam logic MODE_PLANAR = 1'b1;

	localparam cfg_idx_t REG_MODE       = cfg_idx_t'(0);
	localparam cfg_idx_t REG_USE_CUSTOM = cfg_idx_t'(1);

	function automatic rgb_t ega_colour(input pal_idx_t idx);
		rgb_t c;
		case (idx)
			4'd0:    c = 24'h000000;
			4'd1:    c = 24'h000080;
			4'd2:    c = 24'h008000;
			4'd3:    c = 24'h008080;
			4'd4:    c = 24'h800000;
			4'd5:    c = 24'h800080;
			4'd6:    c = 24'h808000;
			4'd7:    c = 24'hC0C0C0;
			4'd8:    c = 24'h808080;
			4'd9:    c = 24'h0000FF;
			4'd10:   c = 24'h00FF00;
			4'd11:   c = 24'h00FFFF;
			4'd12:   c = 24'hFF0000;
			4'd13:   c = 24'hFF00FF;
			4'd14:   c = 24'hFFFF00;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/elpe_ifs.sv]
// ---------------------------------------------------------------------------
// EGA logo pixel expander channel interfaces
// Input item, result item and configuration write channels.
// ---------------------------------------------------------------------------
`default_nettype none

interface elpe_in_if;
	logic                   valid;
	logic                   ready;
	logic                   kind;
	elpe_pkg::plane_t       attribute;
	elpe_pkg::plane_t       pattern;
	elpe_pkg::plane_t       plane_red;
	elpe_pkg::plane_t       plane_green;
	elpe_pkg::plane_t       plane_blue;
	elpe_pkg::plane_t       plane_intensity;
	elpe_pkg::pal_idx_t     palette_index;
	elpe_pkg::comp_t        pal_red;
	elpe_pkg::comp_t        pal_green;
	elpe_pkg::comp_t        pal_blue;

	modport source (
		output valid, kind, attribute, pattern, plane_red, plane_green, plane_blue,
		       plane_intensity, palette_index, pal_red, pal_green, pal_blue,
		input  ready
	);
	modport sink (
		input  valid, kind, attribute, pattern, plane_red, plane_green, plane_blue,
		       plane_intensity, palette_index, pal_red, pal_green, pal_blue,
		output ready
	);
endinterface

interface elpe_out_if;
	logic               valid;
	logic               ready;
	elpe_pkg::rgb_t     pixel_rgb;
	logic               last_pixel;

	modport source (output valid, pixel_rgb, last_pixel, input ready);
	modport sink (input valid, pixel_rgb, last_pixel, output ready);
endinterface

interface elpe_cfg_if;
	logic                  valid;
	logic                  ready;
	elpe_pkg::cfg_idx_t    index;
	elpe_pkg::cfg_data_t   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/elpe_ram.sv]
// ---------------------------------------------------------------------------
// EGA logo pixel expander generic RAM
// One write port, one read port with registered read data (old data on a
// same-address collision).
// ---------------------------------------------------------------------------
`default_nettype none

module elpe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/ega_logo_pixel_expander_unit.sv]
// ---------------------------------------------------------------------------
// EGA logo pixel expander
// Expands attribute/pattern cells or planar RGBI bytes into 24-bit pixels.
// ---------------------------------------------------------------------------
// A pixel item yields eight result items, one per clock unless the output
// stalls, most significant bit first, with last_pixel set on the eighth; the
// custom palette RAM has a single read port and is read once per pixel. The
// next pixel item is taken in the cycle its predecessor issues its last
// lookup. A palette-write item yields no result and is taken only when no
// pixel group is being issued or in the cycle the current group issues its
// last lookup. After its item is accepted, the first pixel passes through the
// group registers, stage s1 and the output register before it is presented.
// Custom palette entries read before they are written return arbitrary
// colours; there is no clearing pass after reset. Configuration writes are
// always ready and must only be made while the block is idle.
`default_nettype none

`include "ega_logo_pixel_expander_unit_macros.svh"

module ega_logo_pixel_expander_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	elpe_in_if.sink   pix_in,
	elpe_out_if.source pix_out,
	elpe_cfg_if.sink  cfg
);

	logic mode_q;
	logic use_custom_q;

	logic                  active_q;
	elpe_pkg::pix_cnt_t    cnt_q;
	elpe_pkg::plane_t      attr_q;
	elpe_pkg::plane_t      pat_q;
	elpe_pkg::plane_t      red_q;
	elpe_pkg::plane_t      green_q;
	elpe_pkg::plane_t      blue_q;
	elpe_pkg::plane_t      inten_q;

	logic                  valid_s1;
	elpe_pkg::pal_idx_t    idx_s1;
	logic                  last_s1;
	logic                  cust_s1;

	logic                  out_valid_q;
	elpe_pkg::rgb_t        pixel_q;
	logic                  last_q;

	logic                  out_free;
	logic                  adv1;
	logic                  issue;
	logic                  grp_done;
	logic                  in_acc;
	logic                  take_grp;
	logic                  pal_we;
	elpe_pkg::pal_idx_t    idx_c;
	elpe_pkg::rgb_t        pal_wdata;
	elpe_pkg::rgb_t        ram_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= elpe_pkg::MODE_ATTR;
			use_custom_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				elpe_pkg::REG_MODE:       mode_q       <= cfg.data[0];
				elpe_pkg::REG_USE_CUSTOM: use_custom_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || pix_out.ready;
	assign adv1     = !valid_s1 || out_free;
	assign issue    = active_q && adv1;
	assign grp_done = issue && (cnt_q == elpe_pkg::LAST_PIX);

	assign pix_in.ready = !active_q || grp_done;
	assign in_acc       = pix_in.valid && pix_in.ready;
	assign take_grp     = in_acc && (pix_in.kind == elpe_pkg::KIND_PIXELS);
	assign pal_we       = in_acc && (pix_in.kind == elpe_pkg::KIND_PAL_WRITE);

	assign pal_wdata = {pix_in.pal_red, 2'b00, pix_in.pal_green, 2'b00,
		pix_in.pal_blue, 2'b00};

	always_comb begin
		if (mode_q == elpe_pkg::MODE_PLANAR) begin
			idx_c = {inten_q[7], red_q[7], green_q[7], blue_q[7]};
		end else begin
			idx_c = pat_q[7] ? attr_q[3:0] : attr_q[7:4];
		end
	end

	// group slot: count pixels issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (take_grp) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (grp_done) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + elpe_pkg::pix_cnt_t'(1);
		end
	end

	// load a new group, advance the bit position on each issue
	always_ff @(posedge clk) begin
		if (take_grp) begin
			attr_q  <= pix_in.attribute;
			pat_q   <= pix_in.pattern;
			red_q   <= pix_in.plane_red;
			green_q <= pix_in.plane_green;
			blue_q  <= pix_in.plane_blue;
			inten_q <= pix_in.plane_intensity;
		end else if (issue) begin
			pat_q   <= {pat_q[6:0], 1'b0};
			red_q   <= {red_q[6:0], 1'b0};
			green_q <= {green_q[6:0], 1'b0};
			blue_q  <= {blue_q[6:0], 1'b0};
			inten_q <= {inten_q[6:0], 1'b0};
		end
	end

	elpe_ram #(
		.WIDTH (elpe_pkg::RGB_W),
		.DEPTH (elpe_pkg::PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pix_in.palette_index),
		.wdata (pal_wdata),
		.re    (issue),
		.raddr (idx_c),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			idx_s1  <= idx_c;
			last_s1 <= (cnt_q == elpe_pkg::LAST_PIX);
			cust_s1 <= (mode_q == elpe_pkg::MODE_PLANAR) && use_custom_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			pixel_q <= cust_s1 ? ram_rdata : elpe_pkg::ega_colour(idx_s1);
			last_q  <= last_s1;
		end
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.pixel_rgb  = pixel_q;
	assign pix_out.last_pixel = last_q;

	`ELPE_ASSERT_NEXT(a_cnt_wrap, grp_done && !take_grp, !active_q && (cnt_q == '0))
	`ELPE_ASSERT_NOW(a_pal_write_gap, pal_we, !active_q || grp_done)
	`ELPE_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv1, valid_s1 && $stable(idx_s1))

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// EGA logo pixel expander testbench
// Drives pixel groups and palette writes through the configuration settings,
// predicts every 24-bit pixel and checks each result item as it arrives.
// ---------------------------------------------------------------------------

module tb_top;

	localparam int                 RESET_CYCLES   = 9;
	localparam int                 SETTLE_CYCLES  = 12;
	localparam int                 STALL_LIMIT    = 1000;
	localparam int                 RANDOM_PHASES  = 8;
	localparam int                 PHASE_ITEMS    = 50;
	localparam elpe_pkg::pal_idx_t LIGHT_GREY_IDX = elpe_pkg::pal_idx_t'(7);
	localparam elpe_pkg::pal_idx_t DARK_GREY_IDX  = elpe_pkg::pal_idx_t'(8);

	typedef struct {
		logic               kind;
		elpe_pkg::plane_t   attribute;
		elpe_pkg::plane_t   pattern;
		elpe_pkg::plane_t   plane_red;
		elpe_pkg::plane_t   plane_green;
		elpe_pkg::plane_t   plane_blue;
		elpe_pkg::plane_t   plane_intensity;
		elpe_pkg::pal_idx_t palette_index;
		elpe_pkg::comp_t    pal_red;
		elpe_pkg::comp_t    pal_green;
		elpe_pkg::comp_t    pal_blue;
	} logo_item_t;

	typedef struct {
		elpe_pkg::rgb_t rgb;
		logic           last;
	} pixel_t;

	logic clk;
	logic arst_n;

	elpe_in_if  pix_in ();
	elpe_out_if pix_out ();
	elpe_cfg_if cfg ();

	ega_logo_pixel_expander_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	logo_item_t  item_q [$];
	pixel_t      pixel_q [$];
	logo_item_t  next_item;

	logic           mode_r;
	logic           use_custom_r;
	elpe_pkg::rgb_t custom_rgb [elpe_pkg::PALETTE_ENTRIES];

	logic        in_fire;
	logic        out_fire;
	logic        no_idle;
	int unsigned in_gap;
	int unsigned out_wait;
	int unsigned stall_cnt;
	int unsigned error_cnt;
	int unsigned group_cnt;
	int unsigned pal_write_cnt;
	int unsigned reg_write_cnt;
	int unsigned pixel_cnt;

	always #5 clk = ~clk;

	function automatic int unsigned idle_draw();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic elpe_pkg::rgb_t ega_lookup(elpe_pkg::pal_idx_t ci);
		logic [7:0] lvl;
		if (ci == LIGHT_GREY_IDX)
			return {3{8'hC0}};
		if (ci == DARK_GREY_IDX)
			return {3{8'h80}};
		lvl = ci[3] ? 8'hFF : 8'h80;
		return {ci[2] ? lvl : 8'h00, ci[1] ? lvl : 8'h00, ci[0] ? lvl : 8'h00};
	endfunction

	function automatic void expand_group(logo_item_t it);
		elpe_pkg::pal_idx_t ci;
		elpe_pkg::rgb_t     c;
		int                 sh;
		if (it.kind == elpe_pkg::KIND_PAL_WRITE) begin
			custom_rgb[it.palette_index] = {it.pal_red, 2'b00, it.pal_green, 2'b00,
				it.pal_blue, 2'b00};
			pal_write_cnt++;
			return;
		end
		group_cnt++;
		for (int k = 0; k < elpe_pkg::PIXELS_PER_BYTE; k++) begin
			sh = elpe_pkg::PIXELS_PER_BYTE - 1 - k;
			if (mode_r == elpe_pkg::MODE_ATTR)
				ci = it.pattern[sh] ? it.attribute[3:0] : it.attribute[7:4];
			else
				ci = {it.plane_intensity[sh], it.plane_red[sh], it.plane_green[sh],
					it.plane_blue[sh]};
			c = (mode_r == elpe_pkg::MODE_PLANAR && use_custom_r) ? custom_rgb[ci]
				: ega_lookup(ci);
			pixel_q.push_back('{rgb: c, last: (k == elpe_pkg::PIXELS_PER_BYTE - 1)});
		end
	endfunction

	function automatic void check_pixel(elpe_pkg::rgb_t rgb, logic last);
		pixel_t want;
		if (pixel_q.size() == 0) begin
			$error("unexpected pixel: pixel_rgb %06h last_pixel %0b", rgb, last);
			error_cnt++;
			return;
		end
		want = pixel_q.pop_front();
		pixel_cnt++;
		if (rgb !== want.rgb) begin
			$error("pixel_rgb expected %06h actual %06h", want.rgb, rgb);
			error_cnt++;
		end
		if (last !== want.last) begin
			$error("last_pixel expected %0b actual %0b", want.last, last);
			error_cnt++;
		end
	endfunction

	function automatic logo_item_t random_item();
		logo_item_t it;
		it.kind            = ($urandom_range(0, 7) == 0) ? elpe_pkg::KIND_PAL_WRITE
			: elpe_pkg::KIND_PIXELS;
		it.attribute       = elpe_pkg::plane_t'($urandom);
		it.pattern         = elpe_pkg::plane_t'($urandom);
		it.plane_red       = elpe_pkg::plane_t'($urandom);
		it.plane_green     = elpe_pkg::plane_t'($urandom);
		it.plane_blue      = elpe_pkg::plane_t'($urandom);
		it.plane_intensity = elpe_pkg::plane_t'($urandom);
		it.palette_index   = elpe_pkg::pal_idx_t'($urandom);
		it.pal_red         = elpe_pkg::comp_t'($urandom);
		it.pal_green       = elpe_pkg::comp_t'($urandom);
		it.pal_blue        = elpe_pkg::comp_t'($urandom);
		return it;
	endfunction

	task automatic push_pixels(elpe_pkg::plane_t attr, elpe_pkg::plane_t pat,
			elpe_pkg::plane_t pr, elpe_pkg::plane_t pg, elpe_pkg::plane_t pb,
			elpe_pkg::plane_t pi);
		logo_item_t it;
		it                 = random_item();
		it.kind            = elpe_pkg::KIND_PIXELS;
		it.attribute       = attr;
		it.pattern         = pat;
		it.plane_red       = pr;
		it.plane_green     = pg;
		it.plane_blue      = pb;
		it.plane_intensity = pi;
		item_q.push_back(it);
	endtask

	task automatic push_palette(elpe_pkg::pal_idx_t idx, elpe_pkg::comp_t r,
			elpe_pkg::comp_t g, elpe_pkg::comp_t b);
		logo_item_t it;
		it               = random_item();
		it.kind          = elpe_pkg::KIND_PAL_WRITE;
		it.palette_index = idx;
		it.pal_red       = r;
		it.pal_green     = g;
		it.pal_blue      = b;
		item_q.push_back(it);
	endtask

	task automatic write_reg(elpe_pkg::cfg_idx_t idx, logic bit_val);
		elpe_pkg::cfg_data_t v;
		v    = elpe_pkg::cfg_data_t'($urandom);
		v[0] = bit_val;
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_mode(logic mode_val, logic custom_val);
		write_reg(elpe_pkg::REG_MODE, mode_val);
		write_reg(elpe_pkg::REG_USE_CUSTOM, custom_val);
	endtask

	task automatic drain();
		do @(posedge clk); while (item_q.size() != 0 || pix_in.valid || pixel_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic planar_sweeps();
		push_pixels(elpe_pkg::plane_t'($urandom), elpe_pkg::plane_t'($urandom),
			8'h0F, 8'h33, 8'h55, 8'h00);
		push_pixels(elpe_pkg::plane_t'($urandom), elpe_pkg::plane_t'($urandom),
			8'h0F, 8'h33, 8'h55, 8'hFF);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			pix_in.valid <= 1'b0;
		end else if (in_fire || !pix_in.valid) begin
			if (in_gap != 0) begin
				pix_in.valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (item_q.size() != 0) begin
				next_item = item_q.pop_front();
				pix_in.kind            <= next_item.kind;
				pix_in.attribute       <= next_item.attribute;
				pix_in.pattern         <= next_item.pattern;
				pix_in.plane_red       <= next_item.plane_red;
				pix_in.plane_green     <= next_item.plane_green;
				pix_in.plane_blue      <= next_item.plane_blue;
				pix_in.plane_intensity <= next_item.plane_intensity;
				pix_in.palette_index   <= next_item.palette_index;
				pix_in.pal_red         <= next_item.pal_red;
				pix_in.pal_green       <= next_item.pal_green;
				pix_in.pal_blue        <= next_item.pal_blue;
				pix_in.valid           <= 1'b1;
				in_gap <= idle_draw();
			end else begin
				pix_in.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_fire)
			out_wait = idle_draw();
		if (out_wait != 0) begin
			pix_out.ready <= 1'b0;
			out_wait--;
		end else begin
			pix_out.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		in_fire  <= arst_n && pix_in.valid && pix_in.ready;
		out_fire <= arst_n && pix_out.valid && pix_out.ready;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				reg_write_cnt++;
				if (cfg.index == elpe_pkg::REG_MODE)
					mode_r = cfg.data[0];
				else if (cfg.index == elpe_pkg::REG_USE_CUSTOM)
					use_custom_r = cfg.data[0];
			end
			if (pix_in.valid && pix_in.ready)
				expand_group('{kind: pix_in.kind, attribute: pix_in.attribute,
					pattern: pix_in.pattern, plane_red: pix_in.plane_red,
					plane_green: pix_in.plane_green, plane_blue: pix_in.plane_blue,
					plane_intensity: pix_in.plane_intensity,
					palette_index: pix_in.palette_index, pal_red: pix_in.pal_red,
					pal_green: pix_in.pal_green, pal_blue: pix_in.pal_blue});
			if (pix_out.valid && pix_out.ready)
				check_pixel(pix_out.pixel_rgb, pix_out.last_pixel);
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
					(cfg.valid && cfg.ready))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		pix_in.valid           = 1'b0;
		pix_in.kind            = elpe_pkg::KIND_PIXELS;
		pix_in.attribute       = '0;
		pix_in.pattern         = '0;
		pix_in.plane_red       = '0;
		pix_in.plane_green     = '0;
		pix_in.plane_blue      = '0;
		pix_in.plane_intensity = '0;
		pix_in.palette_index   = '0;
		pix_in.pal_red         = '0;
		pix_in.pal_green       = '0;
		pix_in.pal_blue        = '0;
		pix_out.ready          = 1'b0;
		cfg.valid              = 1'b0;
		cfg.index              = elpe_pkg::REG_MODE;
		cfg.data               = '0;
		mode_r                 = elpe_pkg::MODE_ATTR;
		use_custom_r           = 1'b0;
		in_fire                = 1'b0;
		out_fire               = 1'b0;
		no_idle                = 1'b0;
		in_gap                 = 0;
		out_wait               = 0;
		stall_cnt              = 0;
		error_cnt              = 0;
		group_cnt              = 0;
		pal_write_cnt          = 0;
		reg_write_cnt          = 0;
		pixel_cnt              = 0;
		foreach (custom_rgb[i])
			custom_rgb[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// custom palette select must not matter in attribute mode
		set_mode(elpe_pkg::MODE_ATTR, 1'b1);
		for (int i = 0; i < elpe_pkg::PALETTE_ENTRIES; i++)
			push_palette(elpe_pkg::pal_idx_t'(i),
				i[0] ? elpe_pkg::comp_t'(63) : elpe_pkg::comp_t'(0),
				i[1] ? elpe_pkg::comp_t'(63) : elpe_pkg::comp_t'(0),
				i[2] ? elpe_pkg::comp_t'(63) : elpe_pkg::comp_t'(i));
		push_pixels(8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_pixels(8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixels(8'h78, 8'hA5, 8'h00, 8'hFF, 8'h00, 8'hFF);
		push_pixels(8'hFF, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h00);
		drain();

		set_mode(elpe_pkg::MODE_PLANAR, 1'b0);
		planar_sweeps();
		drain();

		set_mode(elpe_pkg::MODE_PLANAR, 1'b1);
		planar_sweeps();
		push_pixels(elpe_pkg::plane_t'($urandom), elpe_pkg::plane_t'($urandom),
			8'hFF, 8'hFF, 8'hFF, 8'hFF);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			no_idle = (p == 3 || p == 6);
			set_mode(p[0], p[1] ^ p[2]);
			repeat (PHASE_ITEMS)
				item_q.push_back(random_item());
			drain();
		end

		$display("covered %0d pixel groups (%0d pixels) and %0d palette writes",
			group_cnt, pixel_cnt, pal_write_cnt);
		$display("across %0d register writes in both modes and palette selections",
			reg_write_cnt);
		if (error_cnt == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
